FILE: design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// property checked on the following edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: design/ffca_pkg.sv
// Package: types and constants of the first-fit coalescing allocator
`timescale 1ns / 1ps
package ffca_pkg;
  localparam int ARENA_BYTES_DEF  = 65536;
  localparam int ALIGN_BYTES_DEF  = 8;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int FREE_SLOTS_DEF   = 64;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO      = 3'd1;
  localparam logic [2:0] ST_OOM       = 3'd2;
  localparam logic [2:0] ST_FREED     = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE = 3'd4;
  localparam logic [2:0] ST_TOO_SMALL = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;

  typedef struct packed {
    logic        action;
    logic [15:0] size;
    logic [15:0] address;
  } req_t;

  typedef struct packed {
    logic [15:0] user_address;
    logic [16:0] chunk_bytes;
    logic        reused;
    logic [2:0]  status;
    logic [16:0] bytes_in_use;
  } rsp_t;
endpackage

FILE: design/first_fit_coalescing_allocator_core.sv
// Top level: first-fit coalescing heap allocator with extent table and header memory
`timescale 1ns / 1ps
// One request at a time: start is taken while busy is low, and out_valid pulses once
// with the result. The time taken is set by the walk over the extent table memory
// and the number of free extents (at most FREE_SLOTS). The search walk and the shift
// that closes or opens a slot together visit each entry at most once, but for the
// entry at which the walk stops. The strobe comes in the cycle right after the
// accepting edge for a zero size, oversized or invalid-address request, after the
// CHK and HDR states for a free that fails the header check, and after the walk, any
// shift and DONE for any other request (an out-of-memory or full table result comes
// from DEC, not DONE). busy drops in the strobe cycle, so the next request can be
// taken at the edge that ends it. After reset a clearing pass writes every header
// entry, one a cycle, with busy held high.
// Results cannot be held off by the receiver.
module first_fit_coalescing_allocator_core #(
  parameter int ARENA_BYTES  = ffca_pkg::ARENA_BYTES_DEF,
  parameter int ALIGN_BYTES  = ffca_pkg::ALIGN_BYTES_DEF,
  parameter int HEADER_BYTES = ffca_pkg::HEADER_BYTES_DEF,
  parameter int FREE_SLOTS   = ffca_pkg::FREE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ffca_pkg::req_t      in_req,
  output logic                out_valid,
  output ffca_pkg::rsp_t      out_rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [0:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  localparam int HDR_SLOTS = (ARENA_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int HW = $clog2(HDR_SLOTS);
  localparam int AW = $clog2(ALIGN_BYTES);
  localparam int SW = $clog2(FREE_SLOTS);
  localparam int CW = SW + 1;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_CHK   = 10'b0000000100,
    S_HDR   = 10'b0000001000,
    S_WALK  = 10'b0000010000,
    S_WDAT  = 10'b0000100000,
    S_DEC   = 10'b0001000000,
    S_SHRD  = 10'b0010000000,
    S_SHWR  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // extent table memory: {start, length}
  logic [32:0] ext_mem [FREE_SLOTS];
  logic [17:0] hdr_mem [HDR_SLOTS];
  logic [32:0] ext_q;
  logic [17:0] hdr_q;

  logic [CW-1:0] count_r;
  logic [16:0]   top_r, inuse_r;
  logic          dfe_r;

  logic          act_r;
  logic [16:0]   need_r, chunk_r, bytes_r;
  logic [CW-1:0] idx_r, p_r;
  logic [HW-1:0] clr_r;
  logic          found_r;
  logic [32:0]   prev_r, cur_r;
  logic          have_prev_r;
  logic          sh_up_r;
  logic [CW-1:0] sh_k_r;
  logic          sh_end_r;

  // extent and header memory port control
  logic          ext_we;
  logic [SW-1:0] ext_wa, ext_ra;
  logic [32:0]   ext_wd;
  logic          hdr_we;
  logic [HW-1:0] hdr_wa, hdr_ra;
  logic [17:0]   hdr_wd;

  ffca_pkg::rsp_t rsp_r, rsp_nxt;
  logic           ov_r, ov_nxt;

  logic [16:0] pad;
  logic [17:0] sum_pad;

  assign pready = 1'b1;
  assign prdata = {31'd0, dfe_r};
  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_rsp = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dfe_r <= 1'b0;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      dfe_r <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (ext_we) ext_mem[ext_wa] <= ext_wd;
    ext_q <= ext_mem[ext_ra];
    if (hdr_we) hdr_mem[hdr_wa] <= hdr_wd;
    hdr_q <= hdr_mem[hdr_ra];
  end

  // pad the request size
  always_comb begin
    sum_pad = {2'd0, in_req.size} + 18'(HEADER_BYTES) + 18'(ALIGN_BYTES - 1);
    sum_pad = sum_pad & ~18'(ALIGN_BYTES - 1);
    pad = sum_pad[17] ? 17'h1FFFF : sum_pad[16:0];
  end

  logic [16:0] ua_chunk;
  logic        ua_ok;
  logic [16:0] hdr_bytes;
  logic [17:0] c_end;
  logic        mprev, mnext;
  logic [17:0] top_sum;

  always_comb begin
    ua_chunk = {1'b0, in_req.address} - 17'(HEADER_BYTES);
    ua_ok = (in_req.address != 16'd0) && ({1'b0, in_req.address} >= 17'(HEADER_BYTES))
            && (ua_chunk[AW-1:0] == '0) && (ua_chunk < top_r)
            && ((ua_chunk >> AW) < 17'(HDR_SLOTS));
    hdr_bytes = {hdr_q[16:1], 1'b0};
    c_end = {1'b0, chunk_r} + {1'b0, bytes_r};
    mprev = have_prev_r && ({2'd0, prev_r[32:17]} + {1'b0, prev_r[16:0]} == {1'b0, chunk_r});
    mnext = (p_r < count_r) && (c_end == {2'd0, cur_r[32:17]});
    top_sum = {1'b0, top_r} + {1'b0, need_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      count_r <= '0;
      top_r <= '0;
      inuse_r <= '0;
      clr_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (ov_nxt) begin
        inuse_r <= rsp_nxt.bytes_in_use;
      end
      if (state_r == S_DONE && act_r == ffca_pkg::ACT_ALLOC && !found_r)
        top_r <= top_r + need_r;
      if (state_r == S_DONE) begin
        if (sh_end_r && !sh_up_r) count_r <= count_r - 1'b1;
        if (sh_end_r && sh_up_r) count_r <= count_r + 1'b1;
      end
    end
  end

  // datapath registers; sh_end_r flags a change of the extent count at DONE
  always_ff @(posedge clk) begin
    rsp_r <= rsp_nxt;
    case (state_r)
      S_IDLE: begin
        act_r <= in_req.action;
        need_r <= pad;
        chunk_r <= ua_chunk;
        idx_r <= '0;
        have_prev_r <= 1'b0;
        found_r <= 1'b0;
        sh_end_r <= 1'b0;
      end
      S_WALK: ;
      S_WDAT: begin
        cur_r <= ext_q;
        idx_r <= idx_r + 1'b1;
        if (act_r == ffca_pkg::ACT_FREE) begin
          if ({1'b0, ext_q[32:17]} <= chunk_r) begin
            prev_r <= ext_q;
            have_prev_r <= 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (state_nxt == S_DEC && state_r == S_WDAT) begin
      p_r <= idx_r;
      found_r <= (act_r == ffca_pkg::ACT_ALLOC) && (ext_q[16:0] >= need_r);
    end
    if (state_r == S_WALK && idx_r >= count_r) p_r <= count_r;
    if (state_r == S_HDR) bytes_r <= hdr_bytes;
    if (state_r == S_DEC) begin
      if (act_r == ffca_pkg::ACT_FREE && !mprev && !mnext) sh_k_r <= count_r;
      else sh_k_r <= p_r;
      if (act_r == ffca_pkg::ACT_ALLOC && found_r) begin
        chunk_r <= {1'b0, cur_r[32:17]};
        if (cur_r[16:0] - need_r >= 17'(HEADER_BYTES)) begin
          bytes_r <= need_r;
          sh_end_r <= 1'b0;
        end else begin
          bytes_r <= cur_r[16:0];
          sh_up_r <= 1'b0;
          sh_end_r <= 1'b1;
        end
      end else if (act_r == ffca_pkg::ACT_ALLOC) begin
        chunk_r <= top_r;
        bytes_r <= need_r;
        sh_end_r <= 1'b0;
      end else if (mprev && mnext) begin
        sh_up_r <= 1'b0;
        sh_end_r <= 1'b1;
      end else if (!mprev && !mnext) begin
        sh_up_r <= 1'b1;
        sh_end_r <= 1'b1;
      end else begin
        sh_end_r <= 1'b0;
      end
    end
    if (state_r == S_SHWR) begin
      if (sh_up_r) sh_k_r <= sh_k_r - 1'b1;
      else sh_k_r <= sh_k_r + 1'b1;
    end
  end

  // control and memory ports
  logic alloc_err, free_err;
  logic [2:0] err_code;
  logic [CW-1:0] sh_src;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = 1'b0;
    rsp_nxt = '0;
    rsp_nxt.bytes_in_use = inuse_r;
    ext_we = 1'b0;
    ext_wa = '0;
    ext_wd = '0;
    ext_ra = idx_r[SW-1:0];
    hdr_we = 1'b0;
    hdr_wa = clr_r;
    hdr_wd = '0;
    hdr_ra = ua_chunk[AW+HW-1:AW];
    alloc_err = 1'b0;
    free_err = 1'b0;
    err_code = ffca_pkg::ST_OK;
    sh_src = sh_up_r ? sh_k_r - 1'b1 : sh_k_r + 1'b1;
    case (state_r)
      S_CLEAR: begin
        hdr_we = 1'b1;
        if (clr_r == HW'(HDR_SLOTS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (in_req.action == ffca_pkg::ACT_ALLOC) begin
            if (in_req.size == 16'd0) begin
              alloc_err = 1'b1; err_code = ffca_pkg::ST_ZERO;
            end else if (sum_pad > 18'(ARENA_BYTES)) begin
              alloc_err = 1'b1; err_code = ffca_pkg::ST_TOO_LARGE;
            end else state_nxt = S_WALK;
          end else begin
            if (!ua_ok) begin
              alloc_err = 1'b1;
              err_code = (in_req.address != 16'd0 && dfe_r) ? ffca_pkg::ST_FREED
                                                              : ffca_pkg::ST_OK;
            end else state_nxt = S_CHK;
          end
          if (alloc_err) begin
            ov_nxt = 1'b1;
            rsp_nxt.status = err_code;
          end
        end
      end
      S_CHK: begin
        hdr_ra = chunk_r[AW+HW-1:AW];
        state_nxt = S_HDR;
      end
      S_HDR: begin
        if (!hdr_q[0]) begin
          free_err = 1'b1; err_code = dfe_r ? ffca_pkg::ST_FREED : ffca_pkg::ST_OK;
        end else if (hdr_bytes < need_r) begin
          free_err = 1'b1; err_code = ffca_pkg::ST_TOO_LARGE;
        end else if (hdr_bytes - need_r >= 17'(HEADER_BYTES)) begin
          free_err = 1'b1; err_code = ffca_pkg::ST_TOO_SMALL;
        end
        if (free_err) begin
          ov_nxt = 1'b1; rsp_nxt.status = err_code; state_nxt = S_IDLE;
        end else state_nxt = S_WALK;
      end
      S_WALK: begin
        if (idx_r >= count_r) state_nxt = S_DEC;
        else state_nxt = S_WDAT;
      end
      S_WDAT: begin
        ext_ra = idx_r[SW-1:0];
        if (act_r == ffca_pkg::ACT_ALLOC) begin
          state_nxt = (ext_q[16:0] >= need_r) ? S_DEC : S_WALK;
        end else begin
          state_nxt = ({1'b0, ext_q[32:17]} > chunk_r) ? S_DEC : S_WALK;
        end
      end
      S_DEC: begin
        if (act_r == ffca_pkg::ACT_ALLOC) begin
          if (!found_r && top_sum > 18'(ARENA_BYTES)) begin
            ov_nxt = 1'b1; rsp_nxt.status = ffca_pkg::ST_OOM; state_nxt = S_IDLE;
          end else if (found_r && cur_r[16:0] - need_r >= 17'(HEADER_BYTES)) begin
            ext_we = 1'b1; ext_wa = p_r[SW-1:0];
            ext_wd = {cur_r[32:17] + need_r[15:0], cur_r[16:0] - need_r};
            state_nxt = S_DONE;
          end else if (found_r) state_nxt = S_SHRD;
          else state_nxt = S_DONE;
        end else begin
          if (mprev && mnext) begin
            ext_we = 1'b1; ext_wa = SW'(p_r - 1'b1);
            ext_wd = {prev_r[32:17], prev_r[16:0] + bytes_r + cur_r[16:0]};
            state_nxt = S_SHRD;
          end else if (mprev) begin
            ext_we = 1'b1; ext_wa = SW'(p_r - 1'b1);
            ext_wd = {prev_r[32:17], prev_r[16:0] + bytes_r};
            state_nxt = S_DONE;
          end else if (mnext) begin
            ext_we = 1'b1; ext_wa = p_r[SW-1:0];
            ext_wd = {chunk_r[15:0], cur_r[16:0] + bytes_r};
            state_nxt = S_DONE;
          end else if (count_r >= CW'(FREE_SLOTS)) begin
            ov_nxt = 1'b1; rsp_nxt.status = ffca_pkg::ST_FULL; state_nxt = S_IDLE;
          end else state_nxt = S_SHRD;
        end
      end
      S_SHRD: begin
        // insert: k goes from count down to p; remove: k from p up
        if (sh_up_r && sh_k_r == p_r) begin
          ext_we = 1'b1; ext_wa = p_r[SW-1:0];
          ext_wd = {chunk_r[15:0], bytes_r};
          state_nxt = S_DONE;
        end else if (!sh_up_r && sh_src >= count_r) begin
          state_nxt = S_DONE;
        end else begin
          ext_ra = sh_src[SW-1:0];
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        ext_we = 1'b1; ext_wa = sh_k_r[SW-1:0]; ext_wd = ext_q;
        state_nxt = S_SHRD;
      end
      S_DONE: begin
        hdr_we = ((chunk_r >> AW) < 17'(HDR_SLOTS));
        hdr_wa = chunk_r[AW+HW-1:AW];
        ov_nxt = 1'b1;
        rsp_nxt.chunk_bytes = bytes_r;
        if (act_r == ffca_pkg::ACT_ALLOC) begin
          hdr_wd = {1'b0, bytes_r | 17'd1};
          rsp_nxt.user_address = chunk_r[15:0] + 16'(HEADER_BYTES);
          rsp_nxt.reused = found_r;
          rsp_nxt.bytes_in_use = inuse_r + bytes_r;
        end else begin
          hdr_wd = {1'b0, bytes_r};
          rsp_nxt.bytes_in_use = (inuse_r >= bytes_r) ? inuse_r - bytes_r : 17'd0;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

FILE: design/ffca_checker.sv
// Port checker for the allocator core, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ffca_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input ffca_pkg::rsp_t out_rsp
);
  `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy || out_valid, "request lost")
  `ASSERT_IMPL(a_status_range, clk, rst_n, out_valid, out_rsp.status <= ffca_pkg::ST_FULL, "bad status")
  `ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && out_rsp.status != ffca_pkg::ST_OK,
    out_rsp.user_address == 16'd0 && out_rsp.chunk_bytes == 17'd0, "failure with payload")
  `ASSERT_IMPL(a_valid_idle, clk, rst_n, out_valid, !busy, "result while busy")
endmodule

bind first_fit_coalescing_allocator_core ffca_checker u_ffca_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_rsp(out_rsp)
);

FILE: verif/first_fit_coalescing_allocator_core_tb.sv
// Testbench: first-fit coalescing allocator core checked against a local allocator model
`timescale 1ns / 1ps
module first_fit_coalescing_allocator_core_tb;
  localparam int ARENA  = ffca_pkg::ARENA_BYTES_DEF;
  localparam int ALIGN  = ffca_pkg::ALIGN_BYTES_DEF;
  localparam int HDR    = ffca_pkg::HEADER_BYTES_DEF;
  localparam int SLOTS  = ffca_pkg::FREE_SLOTS_DEF;
  localparam int HSLOTS = (ARENA + ALIGN - 1) / ALIGN;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int RAND_ITEMS  = 1500;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;
  typedef struct {
    row_kind_t      kind;
    ffca_pkg::req_t req;
    bit             typed;
    ffca_pkg::rsp_t rsp;
  } stim_row_t;
  typedef struct {
    int unsigned addr;
    int unsigned size;
  } live_chunk_t;

  logic clk, rst_n, start, busy, out_valid;
  ffca_pkg::req_t in_req;
  ffca_pkg::rsp_t out_rsp;
  logic psel, penable, pwrite, pready;
  logic [0:0] paddr;
  logic [31:0] pwdata, prdata;

  first_fit_coalescing_allocator_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_rsp(out_rsp), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // allocator model state
  int unsigned free_start[SLOTS];
  int unsigned free_len[SLOTS];
  int unsigned free_cnt;
  int unsigned heap_top;
  int unsigned chunk_tag[HSLOTS];
  int unsigned bytes_used;
  bit          strict_free;

  ffca_pkg::rsp_t pending_rsp[$];
  live_chunk_t    live[$];
  stim_row_t      dir_rows[$];
  int             err_cnt;
  int unsigned    cycle_cnt;
  bit             no_gaps;

  function automatic int unsigned padded(int unsigned user);
    return ((user + HDR + ALIGN - 1) / ALIGN) * ALIGN;
  endfunction

  function automatic void drop_extent(int unsigned i);
    for (int unsigned k = i; k + 1 < free_cnt; k++) begin
      free_start[k] = free_start[k + 1];
      free_len[k] = free_len[k + 1];
    end
    free_cnt--;
  endfunction

  function automatic ffca_pkg::rsp_t mk_rsp(int unsigned ua, int unsigned cb, bit ru,
                                            logic [2:0] st);
    ffca_pkg::rsp_t r;
    r.user_address = ua[15:0];
    r.chunk_bytes = cb[16:0];
    r.reused = ru;
    r.status = st;
    r.bytes_in_use = bytes_used[16:0];
    return r;
  endfunction

  function automatic ffca_pkg::rsp_t alloc_model(int unsigned size);
    int unsigned need, i, chunk, bytes;
    bit hit;
    hit = 0;
    if (size == 0) return mk_rsp(0, 0, 0, ffca_pkg::ST_ZERO);
    need = padded(size);
    if (need > ARENA) return mk_rsp(0, 0, 0, ffca_pkg::ST_TOO_LARGE);
    for (i = 0; i < free_cnt; i++)
      if (free_len[i] >= need) begin
        hit = 1;
        break;
      end
    if (hit) begin
      chunk = free_start[i];
      if (free_len[i] - need >= HDR) begin
        free_start[i] += need;
        free_len[i] -= need;
        bytes = need;
      end else begin
        bytes = free_len[i];
        drop_extent(i);
      end
    end else begin
      if (heap_top + need > ARENA) return mk_rsp(0, 0, 0, ffca_pkg::ST_OOM);
      chunk = heap_top;
      heap_top += need;
      bytes = need;
    end
    chunk_tag[chunk / ALIGN] = bytes | 1;
    bytes_used = (bytes_used + bytes) & 32'h1FFFF;
    return mk_rsp(chunk + HDR, bytes, hit, ffca_pkg::ST_OK);
  endfunction

  function automatic ffca_pkg::rsp_t free_model(int unsigned size, int unsigned addr);
    int unsigned chunk, idx, tag, bytes, need, p;
    bit ok, mprev, mnext;
    tag = 0;
    if (addr == 0) return mk_rsp(0, 0, 0, ffca_pkg::ST_OK);
    ok = addr >= HDR;
    chunk = ok ? addr - HDR : 0;
    idx = chunk / ALIGN;
    if (ok && (chunk % ALIGN != 0 || chunk >= heap_top || idx >= HSLOTS)) ok = 0;
    if (ok) tag = chunk_tag[idx];
    if (!ok || tag[0] == 1'b0)
      return mk_rsp(0, 0, 0, strict_free ? ffca_pkg::ST_FREED : ffca_pkg::ST_OK);
    bytes = tag & ~32'd1;
    need = padded(size);
    if (bytes < need) return mk_rsp(0, 0, 0, ffca_pkg::ST_TOO_LARGE);
    if (bytes > need && bytes - need >= HDR) return mk_rsp(0, 0, 0, ffca_pkg::ST_TOO_SMALL);
    for (p = 0; p < free_cnt; p++)
      if (free_start[p] > chunk) break;
    mnext = p < free_cnt && chunk + bytes == free_start[p];
    mprev = p > 0 && free_start[p - 1] + free_len[p - 1] == chunk;
    if (mprev && mnext) begin
      free_len[p - 1] += bytes + free_len[p];
      drop_extent(p);
    end else if (mprev) begin
      free_len[p - 1] += bytes;
    end else if (mnext) begin
      free_start[p] = chunk;
      free_len[p] += bytes;
    end else begin
      if (free_cnt >= SLOTS) return mk_rsp(0, 0, 0, ffca_pkg::ST_FULL);
      for (int unsigned k = free_cnt; k > p; k--) begin
        free_start[k] = free_start[k - 1];
        free_len[k] = free_len[k - 1];
      end
      free_start[p] = chunk;
      free_len[p] = bytes;
      free_cnt++;
    end
    chunk_tag[idx] = bytes;
    bytes_used = (bytes_used >= bytes) ? bytes_used - bytes : 0;
    return mk_rsp(0, bytes, 0, ffca_pkg::ST_OK);
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned exp);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, exp, cycle_cnt);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[first_fit_coalescing_allocator_core] ERROR");
      $finish;
    end
  end

  // result checker: one strobe, one expectation
  always @(posedge clk) begin
    ffca_pkg::rsp_t e;
    if (rst_n && out_valid) begin
      if (pending_rsp.size() == 0) begin
        report("unexpected result", out_rsp.status, 0);
      end else begin
        e = pending_rsp.pop_front();
        if (out_rsp.user_address !== e.user_address)
          report("user_address", out_rsp.user_address, e.user_address);
        if (out_rsp.chunk_bytes !== e.chunk_bytes)
          report("chunk_bytes", out_rsp.chunk_bytes, e.chunk_bytes);
        if (out_rsp.reused !== e.reused) report("reused", out_rsp.reused, e.reused);
        if (out_rsp.status !== e.status) report("status", out_rsp.status, e.status);
        if (out_rsp.bytes_in_use !== e.bytes_in_use)
          report("bytes_in_use", out_rsp.bytes_in_use, e.bytes_in_use);
      end
    end
  end

  // issue one request; start stays high unless a random gap is inserted, so back-to-back requests need no toggle
  task automatic issue(input ffca_pkg::req_t r, input bit typed,
                       input ffca_pkg::rsp_t typed_rsp, output ffca_pkg::rsp_t predicted);
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    if (r.action == ffca_pkg::ACT_ALLOC) predicted = alloc_model(r.size);
    else predicted = free_model(r.size, r.address);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic set_strict(input bit v);
    start <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0 || busy) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    strict_free = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[0] !== v) report("register readback", prdata[0], v);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void row(row_kind_t k, logic act, int unsigned sz, int unsigned ad,
                              bit typed, int unsigned ua, int unsigned cb, bit ru,
                              logic [2:0] st, int unsigned iu);
    stim_row_t s;
    s.kind = k;
    s.req.action = act;
    s.req.size = sz[15:0];
    s.req.address = ad[15:0];
    s.typed = typed;
    s.rsp.user_address = ua[15:0];
    s.rsp.chunk_bytes = cb[16:0];
    s.rsp.reused = ru;
    s.rsp.status = st;
    s.rsp.bytes_in_use = iu[16:0];
    dir_rows.push_back(s);
  endfunction

  initial begin
    ffca_pkg::req_t r;
    ffca_pkg::rsp_t p;
    live_chunk_t lc;
    int unsigned j, n_alloc, n_ops;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_req <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    err_cnt = 0;
    cycle_cnt = 0;
    no_gaps = 0;
    free_cnt = 0;
    heap_top = 0;
    bytes_used = 0;
    strict_free = 0;
    foreach (chunk_tag[i]) chunk_tag[i] = 0;
    foreach (free_start[i]) begin
      free_start[i] = 0;
      free_len[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    row(ROW_REQ, ffca_pkg::ACT_ALLOC, 0, 0, 1, 0, 0, 0, ffca_pkg::ST_ZERO, 0);
    row(ROW_REQ, ffca_pkg::ACT_ALLOC, 65535, 0, 1, 0, 0, 0, ffca_pkg::ST_TOO_LARGE, 0);
    row(ROW_REQ, ffca_pkg::ACT_FREE, 0, 0, 1, 0, 0, 0, ffca_pkg::ST_OK, 0);
    row(ROW_REQ, ffca_pkg::ACT_FREE, 8, 5, 1, 0, 0, 0, ffca_pkg::ST_OK, 0);
    row(ROW_REQ, ffca_pkg::ACT_ALLOC, 8, 16'hFFFF, 1, 24, 32, 0, ffca_pkg::ST_OK, 32);
    row(ROW_REQ, ffca_pkg::ACT_ALLOC, 1, 0, 1, 56, 32, 0, ffca_pkg::ST_OK, 64);
    row(ROW_REQ, ffca_pkg::ACT_ALLOC, 100, 0, 1, 88, 128, 0, ffca_pkg::ST_OK, 192);
    row(ROW_REQ, ffca_pkg::ACT_ALLOC, 65512, 0, 1, 0, 0, 0, ffca_pkg::ST_OOM, 192);
    row(ROW_REQ, ffca_pkg::ACT_FREE, 100, 24, 1, 0, 0, 0, ffca_pkg::ST_TOO_LARGE, 192);
    row(ROW_REQ, ffca_pkg::ACT_FREE, 8, 88, 1, 0, 0, 0, ffca_pkg::ST_TOO_SMALL, 192);
    row(ROW_REQ, ffca_pkg::ACT_FREE, 8, 28, 1, 0, 0, 0, ffca_pkg::ST_OK, 192);
    row(ROW_REQ, ffca_pkg::ACT_FREE, 8, 24, 0, 0, 0, 0, ffca_pkg::ST_OK, 0);
    row(ROW_REQ, ffca_pkg::ACT_FREE, 8, 24, 1, 0, 0, 0, ffca_pkg::ST_OK, 160);
    row(ROW_CFG, 0, 1, 0, 0, 0, 0, 0, ffca_pkg::ST_OK, 0);
    row(ROW_REQ, ffca_pkg::ACT_FREE, 8, 24, 1, 0, 0, 0, ffca_pkg::ST_FREED, 160);
    row(ROW_REQ, ffca_pkg::ACT_FREE, 0, 65535, 1, 0, 0, 0, ffca_pkg::ST_FREED, 160);
    row(ROW_REQ, ffca_pkg::ACT_FREE, 100, 88, 0, 0, 0, 0, ffca_pkg::ST_OK, 0);
    row(ROW_REQ, ffca_pkg::ACT_FREE, 1, 56, 0, 0, 0, 0, ffca_pkg::ST_OK, 0);
    row(ROW_REQ, ffca_pkg::ACT_ALLOC, 8, 0, 0, 0, 0, 0, ffca_pkg::ST_OK, 0);
    row(ROW_REQ, ffca_pkg::ACT_ALLOC, 150, 0, 0, 0, 0, 0, ffca_pkg::ST_OK, 0);
    row(ROW_REQ, ffca_pkg::ACT_ALLOC, 64000, 0, 0, 0, 0, 0, ffca_pkg::ST_OK, 0);
    row(ROW_CFG, 0, 0, 0, 0, 0, 0, 0, ffca_pkg::ST_OK, 0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) set_strict(dir_rows[i].req.size[0]);
      else issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp, p);
    end

    // phases: a run of allocations, then mostly proper frees of live chunks plus noise
    n_ops = 0;
    while (n_ops < RAND_ITEMS) begin
      set_strict(1'($urandom_range(0, 1)));
      n_alloc = $urandom_range(20, 160);
      repeat (n_alloc) begin
        r.action = ffca_pkg::ACT_ALLOC;
        r.address = 16'($urandom);
        case ($urandom_range(0, 19))
          0: r.size = 16'($urandom);
          1: r.size = 16'd0;
          2: r.size = 16'($urandom_range(1000, 8000));
          default: r.size = 16'($urandom_range(1, 64));
        endcase
        if (n_ops > RAND_ITEMS - 200) no_gaps = 1;
        issue(r, 0, '0, p);
        n_ops++;
        if (p.status == ffca_pkg::ST_OK) begin
          lc.addr = p.user_address;
          lc.size = r.size;
          live.push_back(lc);
        end
      end
      repeat ($urandom_range(n_alloc / 2, n_alloc + 10)) begin
        r.action = ffca_pkg::ACT_FREE;
        if (live.size() != 0 && $urandom_range(0, 9) < 8) begin
          j = $urandom_range(0, live.size() - 1);
          r.address = 16'(live[j].addr);
          r.size = 16'(live[j].size);
          if ($urandom_range(0, 15) == 0) r.size = 16'($urandom);
        end else begin
          j = 0;
          r.size = 16'($urandom);
          case ($urandom_range(0, 3))
            0: r.address = 16'd0;
            1: r.address = 16'($urandom);
            default: r.address = 16'((live.size() != 0) ?
                live[$urandom_range(0, live.size() - 1)].addr + 8 : $urandom);
          endcase
        end
        if (n_ops > RAND_ITEMS - 200) no_gaps = 1;
        issue(r, 0, '0, p);
        n_ops++;
        if (p.status == ffca_pkg::ST_OK && p.chunk_bytes != 0) begin
          for (int k = 0; k < live.size(); k++)
            if (live[k].addr == r.address) begin
              live.delete(k);
              break;
            end
        end
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[first_fit_coalescing_allocator_core] OK");
    end else begin
      $display("[first_fit_coalescing_allocator_core] ERROR");
    end
    $finish;
  end
endmodule
